### sv/assembly_source_tokenizer_defines.svh
// ============================================================================
// assembly_source_tokenizer_defines
// Assertion macros used by the tokenizer top level.
// ============================================================================
`ifndef ASSEMBLY_SOURCE_TOKENIZER_DEFINES_SVH
`define ASSEMBLY_SOURCE_TOKENIZER_DEFINES_SVH

`ifndef ASSERT_OFF
// antecedent implies consequent in the same cycle
`define ATOK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// antecedent implies consequent from the next cycle on
`define ATOK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> cons) \
        else $error(msg);
`else
`define ATOK_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define ATOK_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

### sv/atok_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// atok_pkg
// Types, character codes and scan helpers for the source tokenizer.
// ============================================================================
package atok_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int LINE_BITS   = 20;
    localparam int MAX_TOKS    = 3;
    localparam int TOK_IDX_W   = 2;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int TDATA_W     = 96;

    // character codes
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_UNDER = 8'h5f;
    localparam logic [7:0] CH_LBRK  = 8'h5b;
    localparam logic [7:0] CH_RBRK  = 8'h5d;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_COMMA = 8'h2c;
    localparam logic [7:0] CH_COLON = 8'h3a;

    typedef enum logic [3:0] {
        TK_EOF      = 4'd0,
        TK_IDENT    = 4'd1,
        TK_NUMBER   = 4'd2,
        TK_LBRACKET = 4'd3,
        TK_RBRACKET = 4'd4,
        TK_LPAREN   = 4'd5,
        TK_RPAREN   = 4'd6,
        TK_COMMA    = 4'd7,
        TK_COLON    = 4'd8,
        TK_DOT      = 4'd9,
        TK_PLUS     = 4'd10,
        TK_MINUS    = 4'd11,
        TK_NEWLINE  = 4'd12,
        TK_UNKNOWN  = 4'd13
    } tok_kind_t;

    typedef enum logic [2:0] {
        MODE_IDLE    = 3'd0,
        MODE_COMMENT = 3'd1,
        MODE_IDENT   = 3'd2,
        MODE_INT     = 3'd3,
        MODE_DOT     = 3'd4,
        MODE_FRAC    = 3'd5,
        MODE_SIGN    = 3'd6
    } scan_mode_t;

    typedef struct packed {
        logic [OFFSET_BITS-1:0] off;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   col;
    } pos_t;

    typedef struct packed {
        tok_kind_t              kind;
        logic [OFFSET_BITS-1:0] start;
        logic [OFFSET_BITS-1:0] len;
        logic [LINE_BITS-1:0]   line;
        logic [LINE_BITS-1:0]   col;
        logic                   last;
    } tok_t;

    // tokens caused by one source byte
    typedef struct packed {
        logic [TOK_IDX_W-1:0]   cnt;
        tok_t [MAX_TOKS-1:0]    toks;
    } bundle_t;

    // outcome of scanning a byte from the idle mode
    typedef struct packed {
        scan_mode_t mode;
        pos_t       pos;
        pos_t       start;
        logic       sign;
        logic       emit;
        tok_t       tok;
    } idle_res_t;

    localparam pos_t POS_RESET = '{off: '0, line: LINE_BITS'(1), col: LINE_BITS'(1)};

    function automatic logic is_digit(logic [7:0] c);
        return c inside {[8'h30:8'h39]};
    endfunction

    function automatic logic is_id_start(logic [7:0] c);
        return (c inside {[8'h41:8'h5a], [8'h61:8'h7a]}) || (c == CH_UNDER);
    endfunction

    function automatic logic is_id_char(logic [7:0] c);
        return is_id_start(c) || is_digit(c);
    endfunction

    // count one byte, saturating
    function automatic pos_t advance(pos_t p, logic [7:0] c);
        pos_t r;
        r = p;
        if (p.off != '1) r.off = p.off + OFFSET_BITS'(1);
        if (c == CH_LF) begin
            if (p.line != '1) r.line = p.line + LINE_BITS'(1);
            r.col = LINE_BITS'(1);
        end else if (p.col != '1) begin
            r.col = p.col + LINE_BITS'(1);
        end
        return r;
    endfunction

    function automatic tok_t make_tok(tok_kind_t kind, pos_t s,
                                      logic [OFFSET_BITS-1:0] end_off);
        tok_t t;
        t.kind  = kind;
        t.start = s.off;
        t.len   = end_off - s.off;
        t.line  = s.line;
        t.col   = s.col;
        t.last  = 1'b0;
        return t;
    endfunction

    function automatic idle_res_t scan_idle(pos_t p, logic [7:0] c, pos_t ts, logic sign);
        idle_res_t r;
        tok_kind_t k;
        r.mode  = MODE_IDLE;
        r.pos   = p;
        r.start = ts;
        r.sign  = sign;
        r.emit  = 1'b0;
        r.tok   = '0;
        k       = TK_UNKNOWN;
        if (c == CH_SP || c == CH_TAB || c == CH_CR) begin
            r.pos = advance(p, c);
        end else if (c == CH_HASH) begin
            r.pos  = advance(p, c);
            r.mode = MODE_COMMENT;
        end else begin
            r.start = p;
            if (is_id_start(c)) begin
                r.pos  = advance(p, c);
                r.mode = MODE_IDENT;
            end else if (is_digit(c)) begin
                r.pos  = advance(p, c);
                r.mode = MODE_INT;
            end else if (c == CH_PLUS || c == CH_MINUS) begin
                r.sign = (c == CH_MINUS);
                r.mode = MODE_SIGN;
            end else begin
                case (c)
                    CH_LBRK:  k = TK_LBRACKET;
                    CH_RBRK:  k = TK_RBRACKET;
                    CH_LPAR:  k = TK_LPAREN;
                    CH_RPAR:  k = TK_RPAREN;
                    CH_COMMA: k = TK_COMMA;
                    CH_COLON: k = TK_COLON;
                    CH_DOT:   k = TK_DOT;
                    CH_LF:    k = TK_NEWLINE;
                    default:  k = TK_UNKNOWN;
                endcase
                r.pos  = advance(p, c);
                r.tok  = make_tok(k, p, r.pos.off);
                r.emit = 1'b1;
            end
        end
        return r;
    endfunction

endpackage
`default_nettype wire

### sv/atok_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// atok_front
// Scan state machine: takes one byte per transaction and builds its tokens.
// ============================================================================
module atok_front (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    accept,
    input  wire  [7:0]             ch,
    input  wire                    is_end,
    output logic                   push,
    output atok_pkg::bundle_t      bundle
);
    import atok_pkg::*;

    scan_mode_t mode_reg, mode_next;
    pos_t       pos_reg, pos_next;
    pos_t       start_reg, start_next;
    logic       sign_reg, sign_next;

    // scan one byte against the current mode
    always_comb begin
        pos_t                 p;
        pos_t                 ts;
        pos_t                 s;
        scan_mode_t           md;
        logic                 sg;
        logic                 do_idle;
        logic [TOK_IDX_W-1:0] n;
        logic [7:0]           sign_ch;
        tok_kind_t            sign_kind;
        idle_res_t            ir;
        tok_t                 t;

        p         = pos_reg;
        ts        = start_reg;
        md        = mode_reg;
        sg        = sign_reg;
        do_idle   = 1'b0;
        n         = '0;
        bundle    = '0;
        sign_ch   = sign_reg ? CH_MINUS : CH_PLUS;
        sign_kind = sign_reg ? TK_MINUS : TK_PLUS;
        ir        = '0;
        s         = pos_reg;
        t         = '0;

        if (is_end) begin
            // close any open token, then eof at the current position
            case (mode_reg)
                MODE_IDENT: begin
                    bundle.toks[n] = make_tok(TK_IDENT, ts, p.off);
                    n = n + TOK_IDX_W'(1);
                end
                MODE_INT, MODE_FRAC: begin
                    bundle.toks[n] = make_tok(TK_NUMBER, ts, p.off);
                    n = n + TOK_IDX_W'(1);
                end
                MODE_DOT: begin
                    bundle.toks[n] = make_tok(TK_NUMBER, ts, p.off);
                    n = n + TOK_IDX_W'(1);
                    s = p;
                    p = advance(p, CH_DOT);
                    bundle.toks[n] = make_tok(TK_DOT, s, p.off);
                    n = n + TOK_IDX_W'(1);
                end
                MODE_SIGN: begin
                    p = advance(p, sign_ch);
                    bundle.toks[n] = make_tok(sign_kind, ts, p.off);
                    n = n + TOK_IDX_W'(1);
                end
                default: ;
            endcase
            t = make_tok(TK_EOF, p, p.off);
            t.last = 1'b1;
            bundle.toks[n] = t;
            n  = n + TOK_IDX_W'(1);
            md = MODE_IDLE;
            p  = POS_RESET;
            ts = POS_RESET;
            sg = 1'b0;
        end else begin
            case (mode_reg)
                MODE_COMMENT: begin
                    if (ch == CH_LF) do_idle = 1'b1;
                    else p = advance(p, ch);
                end
                MODE_IDENT: begin
                    if (is_id_char(ch)) begin
                        p = advance(p, ch);
                    end else begin
                        bundle.toks[n] = make_tok(TK_IDENT, ts, p.off);
                        n = n + TOK_IDX_W'(1);
                        do_idle = 1'b1;
                    end
                end
                MODE_INT: begin
                    if (is_digit(ch)) begin
                        p = advance(p, ch);
                    end else if (ch == CH_DOT) begin
                        md = MODE_DOT;
                    end else begin
                        bundle.toks[n] = make_tok(TK_NUMBER, ts, p.off);
                        n = n + TOK_IDX_W'(1);
                        do_idle = 1'b1;
                    end
                end
                MODE_DOT: begin
                    if (is_digit(ch)) begin
                        p  = advance(advance(p, CH_DOT), ch);
                        md = MODE_FRAC;
                    end else begin
                        bundle.toks[n] = make_tok(TK_NUMBER, ts, p.off);
                        n = n + TOK_IDX_W'(1);
                        s = p;
                        p = advance(p, CH_DOT);
                        bundle.toks[n] = make_tok(TK_DOT, s, p.off);
                        n = n + TOK_IDX_W'(1);
                        do_idle = 1'b1;
                    end
                end
                MODE_FRAC: begin
                    if (is_digit(ch)) begin
                        p = advance(p, ch);
                    end else begin
                        bundle.toks[n] = make_tok(TK_NUMBER, ts, p.off);
                        n = n + TOK_IDX_W'(1);
                        do_idle = 1'b1;
                    end
                end
                MODE_SIGN: begin
                    if (is_digit(ch)) begin
                        p  = advance(advance(p, sign_ch), ch);
                        md = MODE_INT;
                    end else begin
                        p = advance(p, sign_ch);
                        bundle.toks[n] = make_tok(sign_kind, ts, p.off);
                        n = n + TOK_IDX_W'(1);
                        do_idle = 1'b1;
                    end
                end
                default: do_idle = 1'b1;
            endcase

            // rescan the byte from idle where the open token closed
            if (do_idle) begin
                ir = scan_idle(p, ch, ts, sg);
                md = ir.mode;
                p  = ir.pos;
                ts = ir.start;
                sg = ir.sign;
                if (ir.emit) begin
                    bundle.toks[n] = ir.tok;
                    n = n + TOK_IDX_W'(1);
                end
            end
        end

        bundle.cnt = n;
        push       = accept && (n != '0);
        mode_next  = md;
        pos_next   = p;
        start_next = ts;
        sign_next  = sg;
    end

    // scan state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            pos_reg   <= POS_RESET;
            start_reg <= POS_RESET;
            sign_reg  <= 1'b0;
        end else if (accept) begin
            mode_reg  <= mode_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            sign_reg  <= sign_next;
        end
    end

endmodule
`default_nettype wire

### sv/atok_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// atok_queue
// Short queue of token bundles between the scanner and the output stage.
// ============================================================================
module atok_queue (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  wire                    push,
    input  atok_pkg::bundle_t      push_data,
    input  wire                    pop,
    output atok_pkg::bundle_t      head,
    output logic                   empty,
    output logic                   full
);
    import atok_pkg::*;

    bundle_t             mem [QDEPTH];
    logic [QPTR_W-1:0]   wptr_reg;
    logic [QPTR_W-1:0]   rptr_reg;
    logic [QCNT_W-1:0]   count_reg, count_next;

    assign head  = mem[rptr_reg];
    assign empty = (count_reg == '0);
    assign full  = (count_reg == QCNT_W'(QDEPTH));

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (push && !pop) count_next = count_reg + QCNT_W'(1);
        else if (pop && !push) count_next = count_reg - QCNT_W'(1);
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) mem[wptr_reg] <= push_data;
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            if (push) wptr_reg <= wptr_reg + QPTR_W'(1);
            if (pop) rptr_reg <= rptr_reg + QPTR_W'(1);
            count_reg <= count_next;
        end
    end

endmodule
`default_nettype wire

### sv/atok_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// atok_back
// Output stage: unpacks queued bundles into single token transactions.
// ============================================================================
module atok_back (
    input  wire                    aclk,
    input  wire                    aresetn,
    input  atok_pkg::bundle_t      head,
    input  wire                    empty,
    output logic                   pop,
    input  wire                    m_tready,
    output logic                   m_tvalid,
    output atok_pkg::tok_t         m_tok
);
    import atok_pkg::*;

    logic                 valid_reg;
    tok_t                 tok_reg;
    logic [TOK_IDX_W-1:0] idx_reg, idx_next;
    logic                 load;
    logic                 last_in_bundle;

    assign m_tvalid       = valid_reg;
    assign m_tok          = tok_reg;
    assign load           = !valid_reg || m_tready;
    assign last_in_bundle = (idx_reg == head.cnt - TOK_IDX_W'(1));
    assign pop            = load && !empty && last_in_bundle;

    // walk through the tokens of the head bundle
    always_comb begin
        idx_next = idx_reg;
        if (load && !empty) begin
            if (last_in_bundle) idx_next = '0;
            else idx_next = idx_reg + TOK_IDX_W'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            idx_reg <= idx_next;
            if (load) valid_reg <= !empty;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && !empty) tok_reg <= head.toks[idx_reg];
    end

endmodule
`default_nettype wire

### sv/assembly_source_tokenizer.sv
`timescale 1ns / 1ps
`default_nettype none
// A token is queued with its closing byte, then loaded into the output register.
// Throughput: one source byte per cycle while the queue is not full; the output
// stage sends one token per cycle while m_tready is high, up to three per byte.
// A four-bundle queue lets input run on while the output is stalled.
// Reset: synchronous aresetn low clears scan state, queue and output valid.
// ============================================================================
// assembly_source_tokenizer
// Streaming tokenizer for assembly source text.
// ============================================================================
`include "assembly_source_tokenizer_defines.svh"
module assembly_source_tokenizer (
    input  wire                            aclk,
    input  wire                            aresetn,
    input  wire                            s_tvalid,
    output logic                           s_tready,
    input  wire  [7:0]                     s_tdata,   // [7:0] ch
    input  wire                            s_tlast,   // is_end
    output logic                           m_tvalid,
    input  wire                            m_tready,
    output logic [atok_pkg::TDATA_W-1:0]   m_tdata,   // [3:0] token_kind,
                                                      // [27:4] start_offset,
                                                      // [51:28] tok_len,
                                                      // [71:52] start_line,
                                                      // [91:72] start_column,
                                                      // [95:92] zero
    output logic                           m_tlast    // last_token
);
    import atok_pkg::*;

    logic    accept;
    logic    push;
    bundle_t push_data;
    bundle_t head;
    logic    q_empty;
    logic    q_full;
    logic    pop;
    tok_t    out_tok;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    atok_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (accept),
        .ch      (s_tdata),
        .is_end  (s_tlast),
        .push    (push),
        .bundle  (push_data)
    );

    atok_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .empty     (q_empty),
        .full      (q_full)
    );

    atok_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .head     (head),
        .empty    (q_empty),
        .pop      (pop),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tok    (out_tok)
    );

    // result packing
    assign m_tdata = {4'b0, out_tok.col, out_tok.line, out_tok.len,
                      out_tok.start, out_tok.kind};
    assign m_tlast = out_tok.last;

    // checks
    `ATOK_ASSERT_IMP(a_eof_len_zero, aclk, aresetn, m_tvalid && m_tlast,
                     m_tdata[51:28] == '0, "eof token with nonzero length")
    `ATOK_ASSERT_IMP(a_last_is_eof, aclk, aresetn, m_tvalid,
                     m_tlast == (m_tdata[3:0] == TK_EOF), "last flag does not match eof kind")
    `ATOK_ASSERT_IMP(a_full_has_output, aclk, aresetn, !s_tready, m_tvalid,
                     "queue full with empty output register")
    `ATOK_ASSERT_NXT(a_end_reaches_output, aclk, aresetn, s_tvalid && s_tready && s_tlast,
                     ##1 m_tvalid, "end of source produced no output")

endmodule
`default_nettype wire
